>>> rtl/core/averaged_scalar_kalman_estimator_defines.svh
// Assertion macros for the averaged scalar Kalman estimator.
`ifndef AVERAGED_SCALAR_KALMAN_ESTIMATOR_DEFINES_SVH
`define AVERAGED_SCALAR_KALMAN_ESTIMATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define ASKE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASKE_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define ASKE_ASSERT(label, clk, rst_n, prop, msg)
`define ASKE_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

>>> rtl/core/aske_pkg.sv
// Shared constants, types and helpers of the averaged scalar Kalman estimator.
package aske_pkg;
    localparam int unsigned READINGS_DEFAULT = 10;
    localparam int unsigned DATA_W = 64;
    localparam int unsigned LIGHT_W = 16;
    localparam int unsigned SUM_W = 32;
    localparam logic [15:0] LIGHT_SCALE = 16'd40;
    localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;
    localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

    localparam logic [2:0] REG_GAIN  = 3'd0;
    localparam logic [2:0] REG_DRIFT = 3'd1;
    localparam logic [2:0] REG_BIAS  = 3'd2;
    localparam logic [2:0] REG_QN    = 3'd3;
    localparam logic [2:0] REG_RN    = 3'd4;

    localparam logic [62:0] RST_GAIN  = 63'd22363238868766;
    localparam logic [63:0] RST_DRIFT = 64'd966968937;
    localparam logic [63:0] RST_BIAS  = 64'd9380209;
    localparam logic [62:0] RST_QN    = 63'd6288;
    localparam logic [62:0] RST_RN    = 63'd1670175170662236;

    typedef struct packed {
        logic start;
        logic div_mode;
    } t_unit_cmd;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            sat_add = a[63] ? SMIN : SMAX;
        end else begin
            sat_add = s;
        end
    endfunction

    function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63]) begin
            sat_sub = a[63] ? SMIN : SMAX;
        end else begin
            sat_sub = s;
        end
    endfunction
endpackage

>>> rtl/core/aske_unit.sv
// Bit-serial Q31.32 multiplier and fractional divider shared by the Kalman step.
`include "averaged_scalar_kalman_estimator_defines.svh"
module aske_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  aske_pkg::t_unit_cmd i_cmd,
    input  logic [63:0]        i_a,
    input  logic [63:0]        i_b,
    output logic               o_busy,
    output logic               o_done,
    output logic [63:0]        o_result
);
    logic [6:0]   r_cnt, n_cnt;
    logic         r_busy, n_busy;
    logic         r_done, n_done;
    logic         r_div, n_div;
    logic         r_neg, n_neg;
    logic         r_sat, n_sat;
    logic [63:0]  r_mcand, n_mcand;
    logic [63:0]  r_mplier, n_mplier;
    logic [127:0] r_acc, n_acc;
    logic [63:0]  r_res, n_res;
    logic [63:0]  ma, mb;
    logic [64:0]  sh;
    logic [127:0] biased;

    always_comb begin
        ma = i_a[63] ? (64'd0 - i_a) : i_a;
        mb = i_b[63] ? (64'd0 - i_b) : i_b;
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_div = r_div;
        n_neg = r_neg;
        n_sat = r_sat;
        n_mcand = r_mcand;
        n_mplier = r_mplier;
        n_acc = r_acc;
        n_res = r_res;
        sh = '0;
        biased = '0;
        if (i_cmd.start) begin
            n_busy = 1'b1;
            n_cnt = '0;
            n_div = i_cmd.div_mode;
            if (i_cmd.div_mode) begin
                // a: numerator >= 0, b: denominator > 0; acc = {rem, lo}
                n_mcand = i_b;
                n_acc = {32'd0, i_a, 32'd0};
                n_sat = ({32'd0, i_a[63:32]} >= i_b);
                n_mplier = '0;
            end else begin
                n_neg = i_a[63] ^ i_b[63];
                n_mcand = ma;
                n_mplier = mb;
                n_acc = '0;
                n_sat = 1'b0;
            end
        end else if (r_busy) begin
            if (r_div) begin
                sh = {r_acc[127:63]};
                n_acc = {r_acc[126:0], 1'b0};
                n_mplier = {r_mplier[62:0], 1'b0};
                if (sh >= {1'b0, r_mcand}) begin
                    n_acc[127:64] = 64'(sh - {1'b0, r_mcand});
                    n_mplier[0] = 1'b1;
                end
            end else begin
                // add into the upper half, then shift the product right by one
                sh = {1'b0, r_acc[127:64]} + (r_mplier[0] ? {1'b0, r_mcand} : 65'd0);
                n_acc = {sh, r_acc[63:1]};
                n_mplier = {1'b0, r_mplier[63:1]};
            end
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd63) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
        if (r_done) begin
            if (r_div) begin
                n_res = (r_sat || r_mplier[63]) ? aske_pkg::SMAX : r_mplier;
            end else begin
                biased = r_neg ? (r_acc + 128'h0000_0000_FFFF_FFFF) : r_acc;
                if (!r_neg) begin
                    n_res = (biased[127:95] != 33'd0) ? aske_pkg::SMAX : biased[95:32];
                end else begin
                    n_res = (biased[127:95] != 33'd0) ? aske_pkg::SMIN
                          : (64'd0 - biased[95:32]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_div <= n_div;
        r_neg <= n_neg;
        r_sat <= n_sat;
        r_mcand <= n_mcand;
        r_mplier <= n_mplier;
        r_acc <= n_acc;
        r_res <= n_res;
    end

    logic r_fin;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin <= 1'b0;
        end else begin
            r_fin <= r_done;
        end
    end

    assign o_busy = r_busy || r_done;
    assign o_done = r_fin;
    assign o_result = r_res;

    `ASKE_ASSERT(a_no_start_busy, i_clk, i_rst_n, !(i_cmd.start && (r_busy || r_done)), "start while busy")
    `ASKE_ASSERT_NEXT(a_done_follows, i_clk, i_rst_n, r_busy && r_cnt == 7'd63, r_done, "no done")
    `ASKE_ASSERT_NEXT(a_fin_follows, i_clk, i_rst_n, r_done, r_fin && !r_busy, "no finish")
endmodule

>>> rtl/core/averaged_scalar_kalman_estimator.sv
// Averaged scalar Kalman estimator: groups light readings, runs one Kalman step per group.
// Each reading is accepted while the block is idle. The last reading of a group starts a Kalman
// step: a predict state, a restoring division of the sum for the mean, then six multiplies and
// one divide run one at a time through a shared bit-serial unit at one bit per cycle; the divide
// is skipped when the gain denominator is not positive. The input stalls during the step; a
// result waiting for the consumer holds back the next group's result, and the input with it.
`include "averaged_scalar_kalman_estimator_defines.svh"
module averaged_scalar_kalman_estimator #(
    parameter int unsigned READINGS_PER_ESTIMATE = aske_pkg::READINGS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_light_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [62:0] o_mean_light,
    output logic [63:0] o_position_estimate,
    output logic [62:0] o_error_variance,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    localparam int unsigned CNT_W = $clog2(READINGS_PER_ESTIMATE + 1);
    localparam logic [63:0] NREAD = 64'(READINGS_PER_ESTIMATE);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_MEAN  = 12'b0000_0000_0010,
        S_CP    = 12'b0000_0000_0100,
        S_CPC   = 12'b0000_0000_1000,
        S_DIV   = 12'b0000_0001_0000,
        S_CX    = 12'b0000_0010_0000,
        S_KI    = 12'b0000_0100_0000,
        S_KC    = 12'b0000_1000_0000,
        S_FP    = 12'b0001_0000_0000,
        S_OUT   = 12'b0010_0000_0000,
        S_WAITU = 12'b0100_0000_0000,
        S_PRED  = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic [62:0] r_gain, r_qn, r_rn;
    logic [63:0] r_drift, r_bias;
    logic [31:0] r_sum, n_sum;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [63:0] r_x, n_x, r_p, n_p;
    logic [63:0] r_mean, n_mean, r_cp, n_cp, r_k, n_k;
    logic [63:0] r_rem, n_rem;
    logic [6:0]  r_bit, n_bit;
    logic        r_go, n_go;
    logic        r_ov, n_ov;
    logic [62:0] r_om, n_om, r_ov_p, n_ov_p;
    logic [63:0] r_ox, n_ox;
    logic        r_issued, n_issued;

    aske_pkg::t_unit_cmd cmd;
    logic [63:0] ua, ub, ures;
    logic        ubusy, udone;
    logic [31:0] add40;
    logic [63:0] t0;
    logic [64:0] rsh;

    aske_unit u_unit (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_a(ua), .i_b(ub),
        .o_busy(ubusy), .o_done(udone), .o_result(ures)
    );

    assign o_stall = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid = r_ov;
    assign o_mean_light = r_om;
    assign o_position_estimate = r_ox;
    assign o_error_variance = r_ov_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= aske_pkg::RST_GAIN;
            r_drift <= aske_pkg::RST_DRIFT;
            r_bias <= aske_pkg::RST_BIAS;
            r_qn <= aske_pkg::RST_QN;
            r_rn <= aske_pkg::RST_RN;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                aske_pkg::REG_GAIN:  r_gain <= i_cfg_data[62:0];
                aske_pkg::REG_DRIFT: r_drift <= i_cfg_data;
                aske_pkg::REG_BIAS:  r_bias <= i_cfg_data;
                aske_pkg::REG_QN:    r_qn <= i_cfg_data[62:0];
                aske_pkg::REG_RN:    r_rn <= i_cfg_data[62:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_sum = r_sum;
        n_cnt = r_cnt;
        n_x = r_x;
        n_p = r_p;
        n_mean = r_mean;
        n_cp = r_cp;
        n_k = r_k;
        n_rem = r_rem;
        n_bit = r_bit;
        n_go = r_go;
        n_ov = r_ov;
        n_om = r_om;
        n_ox = r_ox;
        n_ov_p = r_ov_p;
        n_issued = r_issued;
        cmd = '0;
        ua = '0;
        ub = '0;
        add40 = 32'(i_light_count) * 32'(aske_pkg::LIGHT_SCALE);
        t0 = '0;
        rsh = '0;
        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_sum = r_sum + add40;
                    if (32'(r_cnt) + 32'd1 >= 32'(READINGS_PER_ESTIMATE)) begin
                        n_cnt = '0;
                        n_state = S_PRED;
                    end else begin
                        n_cnt = CNT_W'(32'(r_cnt) + 32'd1);
                    end
                end
            end
            S_PRED: begin
                n_p = aske_pkg::sat_add(r_p, {1'b0, r_qn});
                t0 = aske_pkg::sat_add(r_x, {r_drift[63], r_drift[63:1]});
                n_x = aske_pkg::sat_sub(t0, r_bias);
                n_rem = '0;
                n_mean = '0;
                n_bit = '0;
                n_state = S_MEAN;
            end
            S_MEAN: begin
                // restoring divide of {sum, 32'b0} by the group size, one bit a cycle
                rsh = {r_rem, (r_bit < 7'd32) ? r_sum[5'd31 - r_bit[4:0]] : 1'b0};
                n_mean = {r_mean[62:0], 1'b0};
                if (rsh >= {1'b0, NREAD}) begin
                    n_rem = 64'(rsh - {1'b0, NREAD});
                    n_mean[0] = 1'b1;
                end else begin
                    n_rem = rsh[63:0];
                end
                n_bit = r_bit + 7'd1;
                if (r_bit == 7'd63) begin
                    n_sum = '0;
                    n_issued = 1'b0;
                    n_state = S_CP;
                end
            end
            S_CP, S_CPC, S_DIV, S_CX, S_KI, S_KC, S_FP: begin
                priority case (r_state)
                    S_CP:  begin ua = r_p;  ub = {1'b0, r_gain}; end
                    S_CPC: begin ua = r_cp; ub = {1'b0, r_gain}; end
                    S_DIV: begin ua = r_cp; ub = r_k; end
                    S_CX:  begin ua = {1'b0, r_gain}; ub = r_x; end
                    S_KI:  begin ua = r_k;  ub = r_rem; end
                    S_KC:  begin ua = r_k;  ub = {1'b0, r_gain}; end
                    default: begin ua = r_k; ub = r_p; end
                endcase
                if (!r_issued) begin
                    if (r_state == S_DIV && (r_k[63] || r_k == 64'd0)) begin
                        n_k = '0;
                        n_state = S_CX;
                    end else begin
                        cmd.start = 1'b1;
                        cmd.div_mode = (r_state == S_DIV);
                        n_issued = 1'b1;
                    end
                end else if (udone) begin
                    n_issued = 1'b0;
                    priority case (r_state)
                        S_CP:  begin n_cp = ures; n_state = S_CPC; end
                        S_CPC: begin n_k = aske_pkg::sat_add(ures, {1'b0, r_rn}); n_state = S_DIV; end
                        S_DIV: begin n_k = ures; n_state = S_CX; end
                        S_CX:  begin n_rem = aske_pkg::sat_sub(r_mean, ures); n_state = S_KI; end
                        S_KI:  begin n_x = aske_pkg::sat_add(r_x, ures); n_state = S_KC; end
                        S_KC:  begin
                            n_k = ($signed(ures) >= $signed(aske_pkg::ONE_Q32)) ? 64'd0
                                : (aske_pkg::ONE_Q32 - ures);
                            n_state = S_FP;
                        end
                        default: begin n_p = ures; n_state = S_WAITU; end
                    endcase
                end
            end
            S_WAITU: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || !i_stall) begin
                    n_ov = 1'b1;
                    n_om = r_mean[62:0];
                    n_ox = r_x;
                    n_ov_p = r_p[62:0];
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_go = ubusy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sum <= '0;
            r_cnt <= '0;
            r_x <= '0;
            r_p <= '0;
            r_ov <= 1'b0;
            r_issued <= 1'b0;
            r_go <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sum <= n_sum;
            r_cnt <= n_cnt;
            r_x <= n_x;
            r_p <= n_p;
            r_ov <= n_ov;
            r_issued <= n_issued;
            r_go <= n_go;
        end
        r_mean <= n_mean;
        r_cp <= n_cp;
        r_k <= n_k;
        r_rem <= n_rem;
        r_bit <= n_bit;
        r_om <= n_om;
        r_ox <= n_ox;
        r_ov_p <= n_ov_p;
    end

    `ASKE_ASSERT(a_idle_unit, i_clk, i_rst_n, !(r_state == S_IDLE && r_go), "unit busy when idle")
    `ASKE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_ov && i_stall, r_ov && $stable(r_ox), "result lost")
    `ASKE_ASSERT(a_var_pos, i_clk, i_rst_n, !r_p[63], "negative variance")
endmodule

>>> test/tb_averaged_scalar_kalman_estimator.sv
// Testbench for the averaged scalar Kalman estimator: random and directed readings, scoreboard.
`timescale 1ns / 1ps

typedef struct {
    logic [62:0] mean_light;
    logic [63:0] position;
    logic [62:0] variance;
} t_kalman_result;

class kalman_scoreboard;
    logic [62:0] gain, q_noise, r_noise;
    logic [63:0] drift, bias;
    logic [31:0] light_sum;
    int unsigned group_count;
    logic signed [63:0] estimate, error_var;
    t_kalman_result pending[$];
    int unsigned mismatches, results_seen, unexpected;

    function new();
        gain = aske_pkg::RST_GAIN;
        drift = aske_pkg::RST_DRIFT;
        bias = aske_pkg::RST_BIAS;
        q_noise = aske_pkg::RST_QN;
        r_noise = aske_pkg::RST_RN;
        light_sum = 0;
        group_count = 0;
        estimate = 0;
        error_var = 0;
        mismatches = 0;
        results_seen = 0;
        unexpected = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] data);
        case (idx)
            aske_pkg::REG_GAIN:  gain = data[62:0];
            aske_pkg::REG_DRIFT: drift = data;
            aske_pkg::REG_BIAS:  bias = data;
            aske_pkg::REG_QN:    q_noise = data[62:0];
            aske_pkg::REG_RN:    r_noise = data[62:0];
            default: ;
        endcase
    endfunction

    function logic signed [63:0] clamp(logic signed [127:0] v);
        if (v > $signed({64'd0, aske_pkg::SMAX})) return aske_pkg::SMAX;
        if (v < $signed({{64{1'b1}}, aske_pkg::SMIN})) return aske_pkg::SMIN;
        return v[63:0];
    endfunction

    function logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [127:0] p;
        p = 128'(a) * 128'(b);
        return clamp(p >>> 32);
    endfunction

    function logic signed [63:0] qadd(logic signed [63:0] a, logic signed [63:0] b);
        return clamp(128'(a) + 128'(b));
    endfunction

    function logic signed [63:0] qsub(logic signed [63:0] a, logic signed [63:0] b);
        return clamp(128'(a) - 128'(b));
    endfunction

    function logic signed [63:0] qdiv(logic signed [63:0] num, logic signed [63:0] den);
        logic [127:0] quo;
        quo = {32'd0, num, 32'd0} / {64'd0, den};
        if (quo > {64'd0, aske_pkg::SMAX}) return aske_pkg::SMAX;
        return quo[63:0];
    endfunction

    function void note_reading(logic [15:0] light);
        t_kalman_result r;
        logic signed [63:0] c, mean, cp, den, k, innov, kc, factor;
        light_sum = light_sum + 32'(light) * 32'(aske_pkg::LIGHT_SCALE);
        group_count = (group_count + 1) & 7'h7F;
        if (group_count < aske_pkg::READINGS_DEFAULT) return;
        mean = ({light_sum, 32'd0}) / aske_pkg::READINGS_DEFAULT;
        light_sum = 0;
        group_count = 0;
        c = {1'b0, gain};
        error_var = qadd(error_var, {1'b0, q_noise});
        estimate = qadd(estimate, $signed(drift) >>> 1);
        estimate = qsub(estimate, bias);
        cp = qmul(error_var, c);
        den = qadd(qmul(cp, c), {1'b0, r_noise});
        k = (den > 0) ? qdiv(cp, den) : 64'sd0;
        innov = qsub(mean, qmul(c, estimate));
        estimate = qadd(estimate, qmul(k, innov));
        kc = qmul(k, c);
        factor = (kc >= $signed(aske_pkg::ONE_Q32)) ? 64'sd0 : $signed(aske_pkg::ONE_Q32) - kc;
        error_var = qmul(factor, error_var);
        r.mean_light = mean[62:0];
        r.position = estimate;
        r.variance = error_var[62:0];
        pending.push_back(r);
    endfunction

    function void check(logic [62:0] mean_light, logic [63:0] position, logic [62:0] variance);
        t_kalman_result e;
        results_seen++;
        if (pending.size() == 0) begin
            unexpected++;
            mismatches++;
            if (mismatches <= 10) $display("ERROR: result with none pending, mean=%h", mean_light);
            return;
        end
        e = pending.pop_front();
        if (e.mean_light !== mean_light || e.position !== position || e.variance !== variance) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("ERROR: result %0d mean exp %h got %h", results_seen, e.mean_light,
                         mean_light);
                $display("       position exp %h got %h, variance exp %h got %h",
                         e.position, position, e.variance, variance);
            end
        end
    endfunction
endclass

module tb_averaged_scalar_kalman_estimator;
    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [15:0] i_light_count;
    logic        o_valid;
    logic        i_stall;
    logic [62:0] o_mean_light;
    logic [63:0] o_position_estimate;
    logic [62:0] o_error_variance;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    kalman_scoreboard sb;
    int unsigned idle_cycles;
    int unsigned readings_sent;
    int unsigned cfg_writes;
    bit sender_idles;
    bit receiver_idles;
    bit timed_out;

    averaged_scalar_kalman_estimator u_top (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("ERROR: watchdog expired, %0d results pending", sb.pending.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin : drain
        int unsigned n;
        wait (i_rst_n === 1'b1);
        forever begin
            n = receiver_idles ? $urandom_range(0, 17) : 0;
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            sb.check(o_mean_light, o_position_estimate, o_error_variance);
        end
    end

    task automatic write_cfg(logic [2:0] idx, logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
        cfg_writes++;
    endtask

    task automatic send_reading(logic [15:0] light);
        int unsigned gap;
        gap = sender_idles ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_light_count <= light;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_reading(light);
        readings_sent++;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_light();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] rand_wide(int unsigned bits);
        logic [63:0] v;
        v = {$urandom, $urandom};
        return (bits >= 64) ? v : (v & ((64'd1 << bits) - 1));
    endfunction

    task automatic run_batch(int unsigned count);
        sender_idles = ($urandom_range(0, 3) != 0);
        receiver_idles = ($urandom_range(0, 3) != 0);
        repeat (count) send_reading(rand_light());
    endtask

    initial begin
        int unsigned ph;
        logic [63:0] v;
        sb = new();
        timed_out = 1'b0;
        idle_cycles = 0;
        readings_sent = 0;
        cfg_writes = 0;
        sender_idles = 1'b1;
        receiver_idles = 1'b1;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_light_count = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field maximum and bit patterns at reset settings
        for (int i = 0; i < 10; i++) send_reading(16'hFFFF);
        for (int i = 0; i < 10; i++) send_reading(i[0] ? 16'hAAAA : 16'h5555);
        settle();

        // zero denominator: no gain and no measurement noise
        write_cfg(aske_pkg::REG_GAIN, 64'd0);
        write_cfg(aske_pkg::REG_RN, 64'd0);
        run_batch(60);
        settle();

        // extreme gain and noise drive products to saturation and the gain past one
        write_cfg(aske_pkg::REG_GAIN, {1'b0, aske_pkg::SMAX[62:0]});
        write_cfg(aske_pkg::REG_QN, {1'b0, aske_pkg::SMAX[62:0]});
        write_cfg(aske_pkg::REG_RN, 64'hFFFF_FFFF_FFFF_FFFF);
        write_cfg(aske_pkg::REG_DRIFT, aske_pkg::SMIN);
        write_cfg(aske_pkg::REG_BIAS, aske_pkg::SMAX);
        run_batch(100);
        settle();

        write_cfg(aske_pkg::REG_RN, 64'd0);
        write_cfg(aske_pkg::REG_QN, 64'd0);
        write_cfg(aske_pkg::REG_GAIN, 64'h0000_0001_0000_0000);
        write_cfg(aske_pkg::REG_DRIFT, aske_pkg::SMAX);
        write_cfg(aske_pkg::REG_BIAS, aske_pkg::SMIN);
        run_batch(100);
        settle();

        for (ph = 0; ph < 8; ph++) begin
            write_cfg(aske_pkg::REG_GAIN, rand_wide($urandom_range(1, 64)));
            write_cfg(aske_pkg::REG_QN, rand_wide($urandom_range(1, 64)));
            write_cfg(aske_pkg::REG_RN, rand_wide($urandom_range(1, 64)));
            v = rand_wide($urandom_range(1, 64));
            write_cfg(aske_pkg::REG_DRIFT, $urandom_range(0, 1) ? -v : v);
            v = rand_wide($urandom_range(1, 64));
            write_cfg(aske_pkg::REG_BIAS, $urandom_range(0, 1) ? -v : v);
            run_batch(115);
            settle();
        end

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
        $display("Sent %0d readings and %0d register writes; checked %0d estimates.",
                 readings_sent, cfg_writes, sb.results_seen);
        $display("Mismatches: %0d (unexpected results: %0d).", sb.mismatches, sb.unexpected);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/aske_pkg.sv
rtl/core/aske_unit.sv
rtl/core/averaged_scalar_kalman_estimator.sv
test/tb_averaged_scalar_kalman_estimator.sv
